// ===== rtl/core/dcmt_pkg.sv =====
// shared types and constants for the driver class match table
package dcmt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_LOOKUP   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } fsm_state_t;

  typedef struct packed {
    logic [7:0] class_code;
    logic [7:0] sub_class;
    logic [7:0] handler;
  } entry_t;

  typedef struct packed {
    logic [7:0] class_code;
    logic [7:0] sub_class;
    logic [7:0] bus;
    logic [4:0] device;
    logic [2:0] func;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] slot_index;
    logic [7:0] handler;
    logic [7:0] bus;
    logic [4:0] device;
    logic [2:0] func;
  } res_t;

endpackage

// ===== rtl/core/dcmt_ram.sv =====
// generic simple dual-port ram with registered read
module dcmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/driver_class_match_table.sv =====
// Handler match table. A register beat (in_tuser = 0) stores class, subclass and handler id
// in the lowest free slot and answers via ST_RESP; slots fill in order and are never freed,
// so a fill count marks the used ones. A lookup beat (in_tuser = 1) scans the used slots
// from slot 0 through the single read port of the entry ram, one slot per cycle, and answers
// on the first match or after the last used slot. One request is in flight at a time;
// the finished result sits in an output register, so the next beat can be taken while it
// waits. Failed registers and lookup misses return all-zero results with out_tuser = 0.
module driver_class_match_table
  import dcmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // class_code[7:0], sub_class[15:8], handler_in[23:16], bus_in[31:24],
  // device_in[36:32], function_in[39:37]
  input  logic [39:0] in_tdata,
  // req_type[0]
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot_index[3:0], handler_out[11:4], bus_out[19:12], device_out[24:20],
  // function_out[27:25], zero pad[31:28]
  output logic [31:0] out_tdata,
  // ok[0]
  output logic [0:0]  out_tuser
);

  fsm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  req_t             req_r, req_nxt;
  res_t             res_r, res_nxt;
  logic             out_vld_r, out_vld_nxt;
  res_t             out_res_r, out_res_nxt;

  logic             in_fire;
  logic             out_free;
  logic             issue;
  logic             hit;
  logic             full;
  logic             ram_we;
  logic             ram_re;
  entry_t           wr_entry;
  entry_t           rd_entry;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign full     = (fill_r == CNT_W'(TABLE_SLOTS));
  assign issue    = (rd_idx_r < fill_r);
  assign hit      = chk_vld_r && (rd_entry.class_code == req_r.class_code)
                    && (rd_entry.sub_class == req_r.sub_class);

  assign wr_entry.class_code = in_tdata[7:0];
  assign wr_entry.sub_class  = in_tdata[15:8];
  assign wr_entry.handler    = in_tdata[23:16];

  dcmt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == REQ_LOOKUP && fill_r != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (hit || !issue) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_tready   = (state_r == ST_IDLE);
    fill_nxt    = fill_r;
    rd_idx_nxt  = rd_idx_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_res_nxt = out_res_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt.class_code = in_tdata[7:0];
          req_nxt.sub_class  = in_tdata[15:8];
          req_nxt.bus        = in_tdata[31:24];
          req_nxt.device     = in_tdata[36:32];
          req_nxt.func       = in_tdata[39:37];
          rd_idx_nxt         = '0;
          res_nxt            = '0;
          if (in_tuser[0] == REQ_REGISTER && !full) begin
            ram_we             = 1'b1;
            fill_nxt           = fill_r + CNT_W'(1);
            res_nxt.ok         = 1'b1;
            res_nxt.slot_index = 4'(fill_r[IDX_W-1:0]);
          end
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, compared the cycle after
        ram_re      = issue;
        chk_vld_nxt = issue && !hit;
        chk_idx_nxt = rd_idx_r[IDX_W-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (hit) begin
          res_nxt.ok         = 1'b1;
          res_nxt.slot_index = 4'(chk_idx_r);
          res_nxt.handler    = rd_entry.handler;
          res_nxt.bus        = req_r.bus;
          res_nxt.device     = req_r.device;
          res_nxt.func       = req_r.func;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_res_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid     = out_vld_r;
  assign out_tuser[0]   = out_res_r.ok;
  assign out_tdata[3:0]   = out_res_r.slot_index;
  assign out_tdata[11:4]  = out_res_r.handler;
  assign out_tdata[19:12] = out_res_r.bus;
  assign out_tdata[24:20] = out_res_r.device;
  assign out_tdata[27:25] = out_res_r.func;
  assign out_tdata[31:28] = 4'b0;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(TABLE_SLOTS))
    else $error("fill count beyond table size");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !full)
    else $error("entry write into a full table");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser[0] == REQ_REGISTER && !full) |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("register beat did not advance fill count");

  a_chk_used: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> ({1'b0, chk_idx_r} < (IDX_W + 1)'(fill_r)))
    else $error("compare of an unused slot");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tdata == '0)
    else $error("failed result carries non-zero fields");
`endif

endmodule

// ===== test/driver_class_match_table_check.sv =====
// checker for the driver class match table: keeps its own table, predicts and compares replies
`timescale 1ns / 100ps
module driver_class_match_table_check
  import dcmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // class_code[7:0], sub_class[15:8], handler_in[23:16], bus_in[31:24],
  // device_in[36:32], function_in[39:37]
  input  logic [39:0] in_tdata,
  // req_type[0]
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // slot_index[3:0], handler_out[11:4], bus_out[19:12], device_out[24:20],
  // function_out[27:25], zero pad[31:28]
  input  logic [31:0] out_tdata,
  // ok[0]
  input  logic [0:0]  out_tuser,
  output int          mismatches,
  output int          pending
);

  logic       slot_taken    [TABLE_SLOTS];
  logic [7:0] slot_cls      [TABLE_SLOTS];
  logic [7:0] slot_sub      [TABLE_SLOTS];
  logic [7:0] slot_handler  [TABLE_SLOTS];

  res_t awaited_replies[$];

  // register: lowest free slot; lookup: lowest used slot with equal class and subclass
  function automatic res_t table_reply(logic req, logic [39:0] beat);
    res_t       r;
    logic [7:0] cls;
    logic [7:0] sub;
    logic       done;
    r    = '0;
    cls  = beat[7:0];
    sub  = beat[15:8];
    done = 1'b0;
    for (int k = 0; k < TABLE_SLOTS && !done; k++) begin
      if (req == REQ_REGISTER) begin
        if (!slot_taken[k]) begin
          slot_taken[k]   = 1'b1;
          slot_cls[k]     = cls;
          slot_sub[k]     = sub;
          slot_handler[k] = beat[23:16];
          r.ok            = 1'b1;
          r.slot_index    = k[3:0];
          done            = 1'b1;
        end
      end else if (slot_taken[k] && slot_cls[k] == cls && slot_sub[k] == sub) begin
        r.ok         = 1'b1;
        r.slot_index = k[3:0];
        r.handler    = slot_handler[k];
        r.bus        = beat[31:24];
        r.device     = beat[36:32];
        r.func       = beat[39:37];
        done         = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      for (int k = 0; k < TABLE_SLOTS; k++) slot_taken[k] = 1'b0;
      awaited_replies.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_replies.size() == 0) begin
          $error("reply beat with no request waiting");
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          compare_field("ok", want.ok, out_tuser[0]);
          compare_field("slot_index", want.slot_index, out_tdata[3:0]);
          compare_field("handler_out", want.handler, out_tdata[11:4]);
          compare_field("bus_out", want.bus, out_tdata[19:12]);
          compare_field("device_out", want.device, out_tdata[24:20]);
          compare_field("function_out", want.func, out_tdata[27:25]);
          compare_field("pad", 0, out_tdata[31:28]);
        end
      end
      if (in_tvalid && in_tready)
        awaited_replies.push_back(table_reply(in_tuser[0], in_tdata));
      pending <= awaited_replies.size();
    end
  end

endmodule

// ===== test/driver_class_match_table_test.sv =====
// top of the driver class match table testbench: stimulus, back-pressure and verdict
`timescale 1ns / 100ps
module driver_class_match_table_test;
  import dcmt_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int RANDOM_PER_PHASE = 406;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [0:0]  out_tuser;

  int mismatches;
  int pending;
  int gap_pct   = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int fill_count = 0;
  int gap_by_phase   [4] = '{0, 58, 0, 27};
  int stall_by_phase [4] = '{0, 0, 58, 27};

  // {sub_class, class_code} of every entry that made it into the table
  logic [15:0] stored_pairs[$];

  always #4 clk = ~clk;

  driver_class_match_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  driver_class_match_table_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_req(logic req, logic [7:0] cls, logic [7:0] sub, logic [7:0] hnd,
                          logic [7:0] bus, logic [4:0] dev, logic [2:0] fn);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {fn, dev, bus, hnd, sub, cls};
    do @(posedge clk); while (!in_tready);
    if (req == REQ_REGISTER && fill_count < TABLE_SLOTS) begin
      fill_count++;
      stored_pairs.push_back({sub, cls});
    end
  endtask

  // hold off until every reply has come back
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_req;
    int          pick;
    logic [15:0] pair;
    pick = $urandom_range(0, 99);
    pair = stored_pairs[$urandom_range(0, stored_pairs.size() - 1)];
    if (pick < 10)
      pair = 16'($urandom);
    else if (pick < 75)
      pair = pair;
    else if (pick < 88)
      pair = pair ^ (16'h1 << $urandom_range(0, 15));   // near miss
    else
      pair = 16'($urandom);
    send_req((pick < 10) ? REQ_REGISTER : REQ_LOOKUP, pair[7:0], pair[15:8],
             8'($urandom), 8'($urandom), 5'($urandom), 3'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: lookup misses with the echo fields zeroed
    send_req(REQ_LOOKUP, 8'h00, 8'h00, 8'hFF, 8'hFF, 5'd31, 3'd7);
    send_req(REQ_REGISTER, 8'h00, 8'h00, 8'hFF, 8'hFF, 5'd31, 3'd7);
    send_req(REQ_REGISTER, 8'hFF, 8'hFF, 8'h00, 8'h00, 5'd0, 3'd0);
    send_req(REQ_REGISTER, 8'h12, 8'h34, 8'h5A, 8'h11, 5'd3, 3'd1);
    // duplicate entry, lookups must still return the lower slot
    send_req(REQ_REGISTER, 8'h12, 8'h34, 8'hA5, 8'h22, 5'd4, 3'd2);
    send_req(REQ_LOOKUP, 8'h00, 8'h00, 8'h00, 8'hFF, 5'd31, 3'd7);
    send_req(REQ_LOOKUP, 8'hFF, 8'hFF, 8'hFF, 8'h00, 5'd0, 3'd0);
    send_req(REQ_LOOKUP, 8'h12, 8'h34, 8'hC3, 8'hA5, 5'd10, 3'd5);
    send_req(REQ_LOOKUP, 8'h12, 8'h35, 8'h00, 8'h5A, 5'd21, 3'd2);
    send_req(REQ_LOOKUP, 8'h13, 8'h34, 8'h00, 8'h5A, 5'd21, 3'd2);
    send_req(REQ_LOOKUP, 8'hFF, 8'h00, 8'h00, 8'h80, 5'd16, 3'd4);
    send_req(REQ_LOOKUP, 8'h00, 8'hFF, 8'hFF, 8'h01, 5'd1, 3'd3);
    for (int k = 0; k < 12; k++)
      send_req(REQ_REGISTER, 8'(k * 37 + 1), 8'(~(k * 11)), 8'(k * 29 + 3),
               8'(k), 5'(k), 3'(k));
    // table full: register fails and leaves the table as it was
    send_req(REQ_REGISTER, 8'h55, 8'hAA, 8'h77, 8'h33, 5'd9, 3'd6);
    send_req(REQ_LOOKUP, stored_pairs[15][7:0], stored_pairs[15][15:8], 8'h00,
             8'hEE, 5'd30, 3'd6);
    send_req(REQ_LOOKUP, 8'h55, 8'hAA, 8'h00, 8'hEE, 5'd30, 3'd6);
    drain;

    for (int phase = 0; phase < 4; phase++) begin
      gap_pct   = gap_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      repeat (RANDOM_PER_PHASE) begin
        random_req;
        if ($urandom_range(0, 99) == 0) drain;
      end
      drain;
    end

    stall_pct = 0;
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
